/* rtl/ravp_pkg.sv */
// ----------------------------------------------------------------------------
// ravp_pkg
// Shared types and constants of the RADIUS accept / VLAN parser.
// ----------------------------------------------------------------------------
package ravp_pkg;

  // Header and attribute checks
  localparam logic [7:0]  ETYPE_HI      = 8'h08;
  localparam logic [7:0]  ETYPE_LO      = 8'h00;
  localparam logic [7:0]  PROTO_UDP     = 8'd17;
  localparam logic [3:0]  IHL_MIN_WORDS = 4'd5;
  localparam logic [11:0] VLAN_MAX      = 12'd4094;
  localparam logic [2:0]  DIGITS_MAX    = 3'd5;
  localparam int          NAME_LIMIT    = 31;

  // Register defaults
  localparam logic [15:0] DEF_SRC_PORT  = 16'd1812;
  localparam logic [7:0]  DEF_ACCEPT    = 8'd2;
  localparam logic [7:0]  DEF_NAME_TYPE = 8'd1;
  localparam logic [7:0]  DEF_VLAN_TYPE = 8'd81;

  // Register indexes
  typedef enum logic [1:0] {
    CFG_SRC_PORT  = 2'd0,
    CFG_ACCEPT    = 2'd1,
    CFG_NAME_TYPE = 2'd2,
    CFG_VLAN_TYPE = 2'd3
  } ravp_cfg_idx_t;

  // Byte parser phase
  typedef enum logic [2:0] {
    PH_HDR,
    PH_TYPE,
    PH_LEN,
    PH_NAME,
    PH_VLAN,
    PH_SKIP,
    PH_STOP
  } ravp_phase_t;

  // Frame-level controller state
  typedef enum logic [1:0] {
    ST_RUN,
    ST_FIN,
    ST_READ,
    ST_SEND
  } ravp_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic byte_en;
    logic fin_en;
    logic rd_en;
    logic next_en;
    logic clear_en;
  } ravp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic found;
    logic last;
  } ravp_sts_t;

endpackage

/* rtl/radius_accept_vlan_parser.sv */
// ----------------------------------------------------------------------------
// radius_accept_vlan_parser
// Parses an Ethernet frame one byte per beat and, for a RADIUS Access-Accept
// in UDP over IPv4, extracts the user name and the ASCII VLAN attribute.
// Frame bytes are taken at one per cycle while no results are pending. After
// the beat marked frame_end the block judges the VLAN, then drains its results:
// either one beat per name byte (found set, with VLAN and name length) or a
// single not-found beat. Each result beat first reads the name RAM and then
// presents the registered data, and holds while out_ready is low; no input
// is taken meanwhile. Configuration is written through the cfg port; the user
// must do so only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module radius_accept_vlan_parser #(
  parameter int NAME_MAX  = 32,
  parameter int MAX_ATTRS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_frame_byte,
  input  logic        in_frame_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_found,
  output logic [11:0] out_vid,
  output logic [4:0]  out_name_length,
  output logic [7:0]  out_name_byte,
  output logic [4:0]  out_name_index,
  output logic        out_run_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  import ravp_pkg::*;

  localparam int NAME_CAP = ((NAME_MAX - 1) > NAME_LIMIT) ? NAME_LIMIT : (NAME_MAX - 1);

  ravp_cmd_t cmd;
  ravp_sts_t sts;

  // registers are always writable
  assign cfg_ready = 1'b1;

  ravp_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_frame_end (in_frame_end),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cmd          (cmd),
    .sts          (sts)
  );

  ravp_dp #(
    .NAME_CAP  (NAME_CAP),
    .MAX_ATTRS (MAX_ATTRS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_valid & cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_frame_byte   (in_frame_byte),
    .out_found       (out_found),
    .out_vid         (out_vid),
    .out_name_length (out_name_length),
    .out_name_byte   (out_name_byte),
    .out_name_index  (out_name_index),
    .out_run_last    (out_run_last)
  );

endmodule

/* rtl/ravp_ram.sv */
// ----------------------------------------------------------------------------
// ravp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ravp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 31,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/ravp_ctrl.sv */
// ----------------------------------------------------------------------------
// ravp_ctrl
// Frame-level controller: byte intake, end-of-frame check, result drain.
// ----------------------------------------------------------------------------
module ravp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_frame_end,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output ravp_pkg::ravp_cmd_t cmd,
  input  ravp_pkg::ravp_sts_t sts
);

  import ravp_pkg::*;

  ravp_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_RUN: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.byte_en = 1'b1;
          if (in_frame_end) begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        cmd.fin_en = 1'b1;
        state_nxt  = ST_READ;
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_SEND;
      end
      ST_SEND: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.last) begin
            cmd.clear_en = 1'b1;
            state_nxt    = ST_RUN;
          end else begin
            cmd.next_en = 1'b1;
            state_nxt   = ST_READ;
          end
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

endmodule

/* rtl/ravp_dp.sv */
// ----------------------------------------------------------------------------
// ravp_dp
// Datapath: header checks, attribute walk, name store, VLAN digits, results.
// ----------------------------------------------------------------------------
module ravp_dp #(
  parameter int NAME_CAP  = 31,
  parameter int MAX_ATTRS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ravp_pkg::ravp_cmd_t cmd,
  output ravp_pkg::ravp_sts_t sts,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_data,
  input  logic [7:0]          in_frame_byte,
  output logic                out_found,
  output logic [11:0]         out_vid,
  output logic [4:0]          out_name_length,
  output logic [7:0]          out_name_byte,
  output logic [4:0]          out_name_index,
  output logic                out_run_last
);

  import ravp_pkg::*;

  localparam int AW = (NAME_CAP > 1) ? $clog2(NAME_CAP) : 1;

  typedef struct packed {
    ravp_phase_t phase;
    logic        bump;
  } ravp_adv_t;

  // End of an attribute: stop when both values are held, else next TLV or skip.
  function automatic ravp_adv_t attr_done(input logic [4:0]  snl,
                                          input logic [11:0] sv,
                                          input logic [7:0]  rem,
                                          input ravp_phase_t na);
    ravp_adv_t a;
    a.bump = 1'b0;
    if (snl != 5'd0 && sv != 12'd0) begin
      a.phase = PH_STOP;
    end else if (rem == 8'd0) begin
      a.phase = na;
      a.bump  = 1'b1;
    end else begin
      a.phase = PH_SKIP;
    end
    return a;
  endfunction

  // configuration registers
  logic [15:0] src_port_r;
  logic [7:0]  accept_r, name_type_r, vlan_type_r;

  // per-frame state
  logic [6:0]  pos_r, pos_nxt;
  logic [3:0]  hw_r, hw_nxt;
  ravp_phase_t phase_r, phase_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic [7:0]  kind_r, kind_nxt;
  logic [4:0]  snl_r, snl_nxt;
  logic [11:0] acc_r, acc_nxt;
  logic [2:0]  dcnt_r, dcnt_nxt;
  logic [11:0] vlan_r, vlan_nxt;
  logic        term_r, term_nxt;
  logic [4:0]  fill_r, fill_nxt;
  logic [4:0]  idx_r, idx_nxt;

  // working values
  logic [7:0]  b;
  logic [7:0]  p8, ihl8;
  logic        ok;
  logic [7:0]  vl;
  logic [4:0]  sl;
  logic [7:0]  rem_dec;
  logic        term_n;
  logic [4:0]  fill_n;
  logic [2:0]  dcnt_n;
  logic        is_dig;
  logic [15:0] digit_v;
  logic        fin_go;
  logic [11:0] fin_acc;
  logic [2:0]  fin_cnt;
  logic [7:0]  cnt_inc;
  ravp_phase_t na_phase;
  ravp_adv_t   adv;

  // name store
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  assign b        = in_frame_byte;
  assign p8       = {1'b0, pos_r};
  assign ihl8     = {2'b00, hw_r, 2'b00};
  assign vl       = b - 8'd2;
  assign sl       = (vl > 8'(NAME_CAP)) ? 5'(NAME_CAP) : vl[4:0];
  assign rem_dec  = rem_r - 8'd1;
  assign is_dig   = (b >= 8'h30) && (b <= 8'h39);
  assign digit_v  = {4'd0, acc_r} * 16'd10 + {12'd0, b[3:0]};
  assign dcnt_n   = dcnt_r + 3'd1;
  assign cnt_inc  = cnt_r + 8'd1;
  assign na_phase = (cnt_inc >= 8'(MAX_ATTRS)) ? PH_STOP : PH_TYPE;
  assign term_n   = term_r | (b == 8'd0);
  assign fill_n   = fill_r + 5'd1;

  ravp_ram #(
    .WIDTH (8),
    .DEPTH (NAME_CAP),
    .AW    (AW)
  ) u_name_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (cmd.rd_en),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (ram_rdata)
  );

  // byte parser, end-of-frame check, drain index and frame clear
  always_comb begin
    pos_nxt   = pos_r;
    hw_nxt    = hw_r;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    kind_nxt  = kind_r;
    snl_nxt   = snl_r;
    acc_nxt   = acc_r;
    dcnt_nxt  = dcnt_r;
    vlan_nxt  = vlan_r;
    term_nxt  = term_r;
    fill_nxt  = fill_r;
    idx_nxt   = idx_r;
    ram_we    = 1'b0;
    ram_waddr = fill_r[AW-1:0];
    ram_wdata = term_n ? 8'd0 : b;
    ok        = 1'b1;
    fin_go    = 1'b0;
    fin_acc   = acc_r;
    fin_cnt   = dcnt_r;
    adv       = '{phase: PH_STOP, bump: 1'b0};

    if (cmd.byte_en) begin
      unique case (phase_r)
        PH_HDR: begin
          // fixed-offset Ethernet/IPv4 checks, then UDP/RADIUS relative to IHL
          if (pos_r == 7'd12) begin
            ok = (b == ETYPE_HI);
          end else if (pos_r == 7'd13) begin
            ok = (b == ETYPE_LO);
          end else if (pos_r == 7'd14) begin
            hw_nxt = b[3:0];
            ok     = (b[3:0] >= IHL_MIN_WORDS);
          end else if (pos_r == 7'd23) begin
            ok = (b == PROTO_UDP);
          end else if (pos_r >= 7'd34) begin
            if (p8 == 8'd14 + ihl8) begin
              ok = (b == src_port_r[15:8]);
            end else if (p8 == 8'd15 + ihl8) begin
              ok = (b == src_port_r[7:0]);
            end else if (p8 == 8'd22 + ihl8) begin
              ok = (b == accept_r);
            end else if (p8 == 8'd41 + ihl8) begin
              phase_nxt = PH_TYPE;
              cnt_nxt   = 8'd0;
            end
          end
          if (!ok) begin
            phase_nxt = PH_STOP;
          end
          if (pos_r != 7'd127) begin
            pos_nxt = pos_r + 7'd1;
          end
        end
        PH_TYPE: begin
          kind_nxt  = b;
          phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          if (b < 8'd2) begin
            phase_nxt = PH_STOP;
          end else begin
            rem_nxt = vl;
            if (kind_r == name_type_r) begin
              snl_nxt  = sl;
              fill_nxt = 5'd0;
              term_nxt = 1'b0;
              if (sl == 5'd0) begin
                adv       = attr_done(sl, vlan_r, vl, na_phase);
                phase_nxt = adv.phase;
                if (adv.bump) cnt_nxt = cnt_inc;
              end else begin
                phase_nxt = PH_NAME;
              end
            end else if (kind_r == vlan_type_r) begin
              acc_nxt   = 12'd0;
              dcnt_nxt  = 3'd0;
              phase_nxt = (vl == 8'd0) ? PH_STOP : PH_VLAN;
            end else begin
              adv       = attr_done(snl_r, vlan_r, vl, na_phase);
              phase_nxt = adv.phase;
              if (adv.bump) cnt_nxt = cnt_inc;
            end
          end
        end
        PH_NAME: begin
          // bytes after a NUL are stored as zero
          rem_nxt  = rem_dec;
          term_nxt = term_n;
          ram_we   = 1'b1;
          fill_nxt = fill_n;
          if (fill_n >= snl_r) begin
            adv       = attr_done(snl_r, vlan_r, rem_dec, na_phase);
            phase_nxt = adv.phase;
            if (adv.bump) cnt_nxt = cnt_inc;
          end
        end
        PH_VLAN: begin
          rem_nxt = rem_dec;
          if (is_dig) begin
            dcnt_nxt = dcnt_n;
            if (digit_v > {4'd0, VLAN_MAX}) begin
              phase_nxt = PH_STOP;
            end else begin
              acc_nxt = digit_v[11:0];
              if (dcnt_n >= DIGITS_MAX || rem_dec == 8'd0) begin
                fin_go  = 1'b1;
                fin_acc = digit_v[11:0];
                fin_cnt = dcnt_n;
              end
            end
          end else begin
            fin_go = 1'b1;
          end
        end
        PH_SKIP: begin
          rem_nxt = rem_dec;
          if (rem_dec == 8'd0) begin
            phase_nxt = na_phase;
            cnt_nxt   = cnt_inc;
          end
        end
        default: ;
      endcase

      // judge a completed VLAN attribute
      if (fin_go) begin
        if (fin_cnt != 3'd0 && fin_acc != 12'd0 && fin_acc <= VLAN_MAX) begin
          vlan_nxt  = fin_acc;
          adv       = attr_done(snl_r, fin_acc, rem_dec, na_phase);
          phase_nxt = adv.phase;
          if (adv.bump) cnt_nxt = cnt_inc;
        end else begin
          phase_nxt = PH_STOP;
        end
      end
    end

    // VLAN cut short by the frame end: judge the digits seen so far
    if (cmd.fin_en && phase_r == PH_VLAN && dcnt_r != 3'd0 && acc_r != 12'd0 &&
        acc_r <= VLAN_MAX) begin
      vlan_nxt = acc_r;
    end

    if (cmd.next_en) begin
      idx_nxt = idx_r + 5'd1;
    end

    // frame done: back to the header
    if (cmd.clear_en) begin
      pos_nxt   = 7'd0;
      hw_nxt    = 4'd0;
      phase_nxt = PH_HDR;
      cnt_nxt   = 8'd0;
      rem_nxt   = 8'd0;
      kind_nxt  = 8'd0;
      snl_nxt   = 5'd0;
      acc_nxt   = 12'd0;
      dcnt_nxt  = 3'd0;
      vlan_nxt  = 12'd0;
      term_nxt  = 1'b0;
      fill_nxt  = 5'd0;
      idx_nxt   = 5'd0;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= 7'd0;
      hw_r    <= 4'd0;
      phase_r <= PH_HDR;
      cnt_r   <= 8'd0;
      rem_r   <= 8'd0;
      kind_r  <= 8'd0;
      snl_r   <= 5'd0;
      acc_r   <= 12'd0;
      dcnt_r  <= 3'd0;
      vlan_r  <= 12'd0;
      term_r  <= 1'b0;
      fill_r  <= 5'd0;
      idx_r   <= 5'd0;
    end else begin
      pos_r   <= pos_nxt;
      hw_r    <= hw_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      rem_r   <= rem_nxt;
      kind_r  <= kind_nxt;
      snl_r   <= snl_nxt;
      acc_r   <= acc_nxt;
      dcnt_r  <= dcnt_nxt;
      vlan_r  <= vlan_nxt;
      term_r  <= term_nxt;
      fill_r  <= fill_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_port_r  <= DEF_SRC_PORT;
      accept_r    <= DEF_ACCEPT;
      name_type_r <= DEF_NAME_TYPE;
      vlan_type_r <= DEF_VLAN_TYPE;
    end else if (cfg_we) begin
      unique case (ravp_cfg_idx_t'(cfg_index))
        CFG_SRC_PORT:  src_port_r  <= cfg_data;
        CFG_ACCEPT:    accept_r    <= cfg_data[7:0];
        CFG_NAME_TYPE: name_type_r <= cfg_data[7:0];
        CFG_VLAN_TYPE: vlan_type_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // result fields
  always_comb begin
    out_found       = (snl_r != 5'd0) && (vlan_r != 12'd0);
    out_vid         = out_found ? vlan_r : 12'd0;
    out_name_length = out_found ? snl_r : 5'd0;
    out_name_index  = out_found ? idx_r : 5'd0;
    out_name_byte   = (out_found && idx_r < fill_r) ? ram_rdata : 8'd0;
    out_run_last    = !out_found || (idx_r == snl_r - 5'd1);
    sts.found       = out_found;
    sts.last        = out_run_last;
  end

endmodule

/* rtl/ravp_checker.sv */
// ----------------------------------------------------------------------------
// ravp_checker
// Port-level checks of the RADIUS accept / VLAN parser, bound to the top.
// ----------------------------------------------------------------------------
module ravp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [7:0]  in_frame_byte,
  input logic        in_frame_end,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_found,
  input logic [11:0] out_vid,
  input logic [4:0]  out_name_length,
  input logic [7:0]  out_name_byte,
  input logic [4:0]  out_name_index,
  input logic        out_run_last,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [1:0]  cfg_index,
  input logic [15:0] cfg_data
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found) && $stable(out_vid) &&
      $stable(out_name_byte) && $stable(out_name_index) && $stable(out_run_last))
    else $error("result beat changed while stalled");

  // no frame byte is taken while results are pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !out_valid)
    else $error("input taken during result drain");

  // not-found beat is a single all-zero last beat
  a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_run_last && out_vid == 12'd0 &&
      out_name_length == 5'd0 && out_name_index == 5'd0 && out_name_byte == 8'd0)
    else $error("malformed not-found beat");

  // found beats carry a legal VLAN and an index inside the name
  a_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_vid != 12'd0 && out_vid <= 12'd4094 &&
      out_name_length != 5'd0 && out_name_index < out_name_length &&
      (out_run_last == (out_name_index == out_name_length - 5'd1)))
    else $error("malformed found beat");

  // a drain continues until its last beat
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_run_last |=> !in_ready)
    else $error("input reopened before last result beat");

endmodule

bind radius_accept_vlan_parser ravp_checker u_ravp_checker (.*);

/* tb/ravp_tb_pkg.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ravp_tb_pkg
// Result beat type and scoreboard for the RADIUS accept / VLAN parser bench.
// The scoreboard runs its own byte-level parse of each frame and queues the
// name beats (or the single not-found beat) that the frame end should drain.
// ----------------------------------------------------------------------------
package ravp_tb_pkg;

  import ravp_pkg::*;

  localparam int TB_NAME_MAX  = 32;
  localparam int TB_MAX_ATTRS = 64;
  localparam int NAME_CAP     = (TB_NAME_MAX - 1 > NAME_LIMIT) ? NAME_LIMIT : TB_NAME_MAX - 1;
  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] ASCII_NINE = 8'h39;

  // One result beat as seen on the out_ channel
  typedef struct {
    logic        found;
    logic [11:0] vlan;
    logic [4:0]  name_length;
    logic [7:0]  name_byte;
    logic [4:0]  name_index;
    logic        run_last;
  } name_beat_t;

  class vlan_name_scoreboard;

    // Register copies
    logic [15:0] src_port;
    logic [7:0]  accept_code;
    logic [7:0]  name_type;
    logic [7:0]  vlan_type;

    // Per-frame parse state
    logic [6:0]  byte_pos;
    logic [3:0]  hdr_words;
    ravp_phase_t phase;
    int          attr_count;
    logic [7:0]  attr_left;
    logic [7:0]  attr_kind;
    logic [7:0]  name_mem [NAME_CAP];
    logic [4:0]  name_len;
    int          digit_acc;
    int          digit_cnt;
    logic [11:0] vlan_id;
    bit          name_nul;
    int          name_fill;

    name_beat_t  pending[$];
    int          errors;

    function new();
      src_port    = DEF_SRC_PORT;
      accept_code = DEF_ACCEPT;
      name_type   = DEF_NAME_TYPE;
      vlan_type   = DEF_VLAN_TYPE;
      errors      = 0;
      clear_frame();
    endfunction

    function void write_reg(ravp_cfg_idx_t idx, logic [15:0] data);
      case (idx)
        CFG_SRC_PORT:  src_port    = data;
        CFG_ACCEPT:    accept_code = data[7:0];
        CFG_NAME_TYPE: name_type   = data[7:0];
        CFG_VLAN_TYPE: vlan_type   = data[7:0];
        default: ;
      endcase
    endfunction

    function void clear_frame();
      byte_pos   = '0;
      hdr_words  = '0;
      phase      = PH_HDR;
      attr_count = 0;
      attr_left  = '0;
      attr_kind  = '0;
      foreach (name_mem[i]) name_mem[i] = '0;
      name_len   = '0;
      digit_acc  = 0;
      digit_cnt  = 0;
      vlan_id    = '0;
      name_nul   = 1'b0;
      name_fill  = 0;
    endfunction

    function void next_attr();
      attr_count++;
      phase = (attr_count >= TB_MAX_ATTRS) ? PH_STOP : PH_TYPE;
    endfunction

    // Stop once both values are held, else move on or skip the rest
    function void attr_done();
      if (name_len != 0 && vlan_id != 0) phase = PH_STOP;
      else if (attr_left == 0) next_attr();
      else phase = PH_SKIP;
    endfunction

    function void vlan_done(bit ok);
      if (ok && digit_cnt > 0 && digit_acc >= 1 && digit_acc <= int'(VLAN_MAX)) begin
        vlan_id = 12'(digit_acc);
        attr_done();
      end else begin
        phase = PH_STOP;
      end
    endfunction

    // Ethernet / IPv4 / UDP / RADIUS header checks
    function void header_byte(logic [7:0] b);
      int p;
      int ihl;
      bit ok;
      p   = int'(byte_pos);
      ihl = int'(hdr_words) * 4;
      ok  = 1'b1;
      if (p == 12) ok = (b == ETYPE_HI);
      else if (p == 13) ok = (b == ETYPE_LO);
      else if (p == 14) begin
        hdr_words = b[3:0];
        ok = (hdr_words >= IHL_MIN_WORDS);
      end else if (p == 23) ok = (b == PROTO_UDP);
      else if (p >= 34) begin
        if (p == 14 + ihl) ok = (b == src_port[15:8]);
        else if (p == 15 + ihl) ok = (b == src_port[7:0]);
        else if (p == 22 + ihl) ok = (b == accept_code);
        else if (p == 41 + ihl) begin
          phase = PH_TYPE;
          attr_count = 0;
        end
      end
      if (!ok) phase = PH_STOP;
      if (byte_pos < 7'd127) byte_pos = byte_pos + 7'd1;
    endfunction

    // Attribute TLV walk
    function void attr_byte(logic [7:0] b);
      logic [7:0] vl;
      int v;
      case (phase)
        PH_TYPE: begin
          attr_kind = b;
          phase = PH_LEN;
        end
        PH_LEN: begin
          if (b < 8'd2) begin
            phase = PH_STOP;
          end else begin
            vl = b - 8'd2;
            attr_left = vl;
            if (attr_kind == name_type) begin
              name_len  = (int'(vl) > NAME_CAP) ? 5'(NAME_CAP) : 5'(vl);
              name_fill = 0;
              name_nul  = 1'b0;
              if (name_len == 0) attr_done();
              else phase = PH_NAME;
            end else if (attr_kind == vlan_type) begin
              digit_acc = 0;
              digit_cnt = 0;
              if (vl == 0) vlan_done(1'b0);
              else phase = PH_VLAN;
            end else begin
              attr_done();
            end
          end
        end
        PH_NAME: begin
          attr_left = attr_left - 8'd1;
          if (b == 8'h00) name_nul = 1'b1;
          if (name_fill < NAME_CAP) name_mem[name_fill] = name_nul ? 8'h00 : b;
          name_fill++;
          if (name_fill >= int'(name_len)) attr_done();
        end
        PH_VLAN: begin
          attr_left = attr_left - 8'd1;
          if (b >= ASCII_ZERO && b <= ASCII_NINE) begin
            v = digit_acc * 10 + int'(b - ASCII_ZERO);
            digit_cnt++;
            if (v > int'(VLAN_MAX)) begin
              phase = PH_STOP;
            end else begin
              digit_acc = v;
              if (digit_cnt >= int'(DIGITS_MAX) || attr_left == 0) vlan_done(1'b1);
            end
          end else begin
            vlan_done(1'b1);
          end
        end
        PH_SKIP: begin
          attr_left = attr_left - 8'd1;
          if (attr_left == 0) next_attr();
        end
        default: ;
      endcase
    endfunction

    // Accepted input beat; a frame end queues that frame's result beats
    function void note_byte(logic [7:0] b, logic last);
      name_beat_t beat;
      if (phase == PH_HDR) header_byte(b);
      else attr_byte(b);
      if (!last) return;
      if (phase == PH_VLAN) vlan_done(1'b1);
      if (name_len != 0 && vlan_id != 0) begin
        for (int i = 0; i < int'(name_len); i++) begin
          beat.found       = 1'b1;
          beat.vlan        = vlan_id;
          beat.name_length = name_len;
          beat.name_byte   = (i < name_fill && i < NAME_CAP) ? name_mem[i] : 8'h00;
          beat.name_index  = 5'(i);
          beat.run_last    = (i == int'(name_len) - 1);
          pending.push_back(beat);
        end
      end else begin
        beat.found       = 1'b0;
        beat.vlan        = '0;
        beat.name_length = '0;
        beat.name_byte   = '0;
        beat.name_index  = '0;
        beat.run_last    = 1'b1;
        pending.push_back(beat);
      end
      clear_frame();
    endfunction

    function void flag(string what, logic [31:0] want, logic [31:0] got);
      errors++;
      if (errors <= 10) $display("mismatch: %s expected %0d got %0d", what, want, got);
    endfunction

    function void check_beat(name_beat_t got);
      name_beat_t want;
      if (pending.size() == 0) begin
        flag("beat with none pending, name_index", 32'd0, 32'(got.name_index));
        return;
      end
      want = pending.pop_front();
      if (got.found !== want.found) flag("found", 32'(want.found), 32'(got.found));
      if (got.vlan !== want.vlan) flag("vlan", 32'(want.vlan), 32'(got.vlan));
      if (got.name_length !== want.name_length)
        flag("name_length", 32'(want.name_length), 32'(got.name_length));
      if (got.name_byte !== want.name_byte)
        flag("name_byte", 32'(want.name_byte), 32'(got.name_byte));
      if (got.name_index !== want.name_index)
        flag("name_index", 32'(want.name_index), 32'(got.name_index));
      if (got.run_last !== want.run_last)
        flag("run_last", 32'(want.run_last), 32'(got.run_last));
    endfunction

  endclass

endpackage

/* tb/radius_accept_vlan_parser_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// radius_accept_vlan_parser_test
// Feeds whole Ethernet frames byte by byte: directed frames for each header
// check, attribute rule and cut-off case, then mostly well-formed RADIUS
// accepts with random content under several register settings. Frames go
// out while they fit in a budget of 210 input beats; a frame that
// would overrun it is dropped unsent. Each drained result beat is compared
// against the scoreboard's own parse of the frame.
// ----------------------------------------------------------------------------
module radius_accept_vlan_parser_test;

  import ravp_pkg::*;
  import ravp_tb_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  // Header corruption choices
  typedef enum int {
    HDR_OK,
    BAD_ETYPE_HI,
    BAD_ETYPE_LO,
    BAD_IHL,
    BAD_PROTO,
    BAD_PORT_HI,
    BAD_PORT_LO,
    BAD_CODE
  } hdr_fault_t;

  localparam logic [7:0] FILLER_TYPE = 8'd26;
  localparam int         BEAT_BUDGET = 210;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_frame_byte = '0;
  logic        in_frame_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_found;
  logic [11:0] out_vid;
  logic [4:0]  out_name_length;
  logic [7:0]  out_name_byte;
  logic [4:0]  out_name_index;
  logic        out_run_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  vlan_name_scoreboard sb = new();
  byte_q_t frame_q;
  int      burst_left = 0;
  int      beats_sent = 0;
  int      rx_tick = 0;
  int      rx_mode = 0;
  int      rx_hold = 0;

  radius_accept_vlan_parser #(
    .NAME_MAX  (TB_NAME_MAX),
    .MAX_ATTRS (TB_MAX_ATTRS)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_frame_byte   (in_frame_byte),
    .in_frame_end    (in_frame_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_found       (out_found),
    .out_vid         (out_vid),
    .out_name_length (out_name_length),
    .out_name_byte   (out_name_byte),
    .out_name_index  (out_name_index),
    .out_run_last    (out_run_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Receiver: switches between randomly chosen stall patterns
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_tick % 97 == 0) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= (rx_tick % 3 == 0);
      default: begin
        if (rx_hold > 0) begin
          out_ready <= 1'b0;
          rx_hold <= rx_hold - 1;
        end else begin
          out_ready <= 1'b1;
          if ($urandom_range(0, 3) == 0) rx_hold <= $urandom_range(2, 7);
        end
      end
    endcase
  end

  // Result beat monitor
  always @(posedge clk) begin : result_monitor
    name_beat_t got;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      got.found       = out_found;
      got.vlan        = out_vid;
      got.name_length = out_name_length;
      got.name_byte   = out_name_byte;
      got.name_index  = out_name_index;
      got.run_last    = out_run_last;
      sb.check_beat(got);
    end
  end

  // Run limit
  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic byte_q_t rand_bytes(int n);
    byte_q_t q;
    for (int i = 0; i < n; i++) q.push_back(8'($urandom));
    return q;
  endfunction

  // Decimal digits with leading zeros, low ndig digits of value
  function automatic byte_q_t ascii_num(int value, int ndig);
    byte_q_t q;
    int v;
    v = value;
    for (int k = 0; k < ndig; k++) begin
      q.push_front(ASCII_ZERO + 8'(v % 10));
      v = v / 10;
    end
    return q;
  endfunction

  function automatic void put_attr(logic [7:0] kind, byte_q_t vals);
    frame_q.push_back(kind);
    frame_q.push_back(8'(vals.size() + 2));
    foreach (vals[i]) frame_q.push_back(vals[i]);
  endfunction

  function automatic void trim(int n);
    repeat (n) void'(frame_q.pop_back());
  endfunction

  // Ethernet + IPv4 (iw words) + UDP + RADIUS header up to the first attribute
  function automatic void put_header(hdr_fault_t fault, int iw);
    int base;
    logic [7:0] b;
    logic [7:0] flip;
    flip = 8'h01 << $urandom_range(0, 7);
    base = 14 + 4 * iw;
    for (int p = 0; p < base + 28; p++) begin
      b = 8'($urandom);
      if (p == 12) b = (fault == BAD_ETYPE_HI) ? ETYPE_HI ^ flip : ETYPE_HI;
      else if (p == 13) b = (fault == BAD_ETYPE_LO) ? ETYPE_LO ^ flip : ETYPE_LO;
      else if (p == 14)
        b = {b[7:4], (fault == BAD_IHL) ? 4'($urandom_range(0, 4)) : 4'(iw)};
      else if (p == 23) b = (fault == BAD_PROTO) ? PROTO_UDP ^ flip : PROTO_UDP;
      else if (p == base)
        b = (fault == BAD_PORT_HI) ? sb.src_port[15:8] ^ flip : sb.src_port[15:8];
      else if (p == base + 1)
        b = (fault == BAD_PORT_LO) ? sb.src_port[7:0] ^ flip : sb.src_port[7:0];
      else if (p == base + 8)
        b = (fault == BAD_CODE) ? sb.accept_code ^ flip : sb.accept_code;
      frame_q.push_back(b);
    end
  endfunction

  function automatic void put_random_name();
    byte_q_t vals;
    int len;
    len = ($urandom_range(0, 6) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
    vals = rand_bytes(len);
    if (len > 0 && $urandom_range(0, 6) == 0) vals[$urandom_range(0, len - 1)] = 8'h00;
    put_attr(sb.name_type, vals);
  endfunction

  // Mostly legal VLAN numbers; some zero, too large, no digit, empty, overlong
  function automatic void put_random_vlan();
    int r;
    int value;
    int ndig;
    int tail;
    r = $urandom_range(0, 99);
    tail = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
    if (r < 60) begin
      value = $urandom_range(1, 4094);
      ndig = (value < 10) ? 1 : (value < 100) ? 2 : (value < 1000) ? 3 : 4;
      if (ndig < 5 && $urandom_range(0, 3) == 0) ndig++;
    end else if (r < 68) begin
      value = 0;
      ndig = $urandom_range(1, 3);
    end else if (r < 76) begin
      value = $urandom_range(4095, 99999);
      ndig = (value < 10000) ? 4 : 5;
    end else if (r < 84) begin
      value = 0;
      ndig = 0;
      tail = $urandom_range(1, 3);
    end else if (r < 90) begin
      value = 0;
      ndig = 0;
      tail = 0;
    end else begin
      value = $urandom_range(0, 9999999);
      ndig = $urandom_range(6, 7);
    end
    put_attr(sb.vlan_type, {ascii_num(value, ndig), rand_bytes(tail)});
  endfunction

  function automatic void put_random_extra();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) put_random_name();
    else if (r < 60) put_random_vlan();
    else if (r < 90) put_attr(8'($urandom), rand_bytes($urandom_range(0, 8)));
    else begin
      frame_q.push_back(8'($urandom));
      frame_q.push_back(8'($urandom_range(0, 1)));
    end
  endfunction

  function automatic void build_random_frame();
    hdr_fault_t fault;
    frame_q.delete();
    if ($urandom_range(0, 99) < 8) begin
      frame_q = rand_bytes($urandom_range(1, 80));
      return;
    end
    fault = HDR_OK;
    if ($urandom_range(0, 99) < 15) fault = hdr_fault_t'($urandom_range(1, 7));
    put_header(fault, ($urandom_range(0, 3) == 0) ? $urandom_range(6, 15) : 5);
    repeat ($urandom_range(0, 3)) put_random_extra();
    if ($urandom_range(0, 9) < 7) begin
      if ($urandom_range(0, 1)) begin
        put_random_name();
        put_random_vlan();
      end else begin
        put_random_vlan();
        put_random_name();
      end
    end
    repeat ($urandom_range(0, 2)) put_random_extra();
    if ($urandom_range(0, 99) < 15) trim($urandom_range(0, frame_q.size() - 1));
    if ($urandom_range(0, 99) < 25) begin
      repeat ($urandom_range(0, 10)) frame_q.push_back(8'($urandom));
    end
  endfunction

  task automatic wait_results();
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // One input beat; the sender idles between bursts of random length
  task automatic send_byte(logic [7:0] b, logic last);
    if (burst_left <= 0) begin
      if ($urandom_range(0, 4) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(24, 64) : $urandom_range(1, 8);
    end
    in_valid      <= 1'b1;
    in_frame_byte <= b;
    in_frame_end  <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_byte(b, last);
    burst_left--;
  endtask

  // A frame goes out only while it fits in the beat budget
  task automatic send_frame();
    if (beats_sent + frame_q.size() <= BEAT_BUDGET) begin
      beats_sent += frame_q.size();
      foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
      in_valid <= 1'b0;
    end
    frame_q.delete();
    wait_results();
  endtask

  task automatic cfg_write(ravp_cfg_idx_t idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  // Registers change only once the block has drained and settled
  task automatic set_config(logic [15:0] port, logic [7:0] code, logic [7:0] ntype,
                            logic [7:0] vtype);
    wait_results();
    repeat (8) @(posedge clk);
    cfg_write(CFG_SRC_PORT, port);
    cfg_write(CFG_ACCEPT, {8'h00, code});
    cfg_write(CFG_NAME_TYPE, {8'h00, ntype});
    cfg_write(CFG_VLAN_TYPE, {8'h00, vtype});
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_directed();
    hdr_fault_t fault;
    // Full-length name first, so every name store entry is written
    put_header(HDR_OK, 5);
    put_attr(sb.name_type, rand_bytes(40));
    put_attr(sb.vlan_type, ascii_num(4094, 4));
    send_frame();
    // Frames that end inside the headers
    frame_q.push_back(8'hFF);
    send_frame();
    repeat (20) frame_q.push_back(8'hFF);
    send_frame();
    // Each header check failing in turn
    for (int f = BAD_ETYPE_HI; f <= BAD_CODE; f++) begin
      fault = hdr_fault_t'(f);
      put_header(fault, 5);
      put_attr(sb.name_type, rand_bytes(3));
      put_attr(sb.vlan_type, ascii_num(10, 2));
      send_frame();
    end
    // Largest IHL, VLAN of one
    put_header(HDR_OK, 15);
    put_attr(sb.name_type, rand_bytes(5));
    put_attr(sb.vlan_type, ascii_num(1, 1));
    send_frame();
    // NUL inside the name, five digits with leading zeros
    put_header(HDR_OK, 5);
    put_attr(sb.name_type, '{8'h61, 8'h62, 8'h00, 8'h63, 8'h64});
    put_attr(sb.vlan_type, ascii_num(100, 5));
    send_frame();
    // Name cut short by the frame end
    put_header(HDR_OK, 5);
    put_attr(sb.vlan_type, ascii_num(7, 1));
    put_attr(sb.name_type, rand_bytes(10));
    trim(7);
    send_frame();
    // VLAN digits cut by the frame end
    put_header(HDR_OK, 5);
    put_attr(sb.name_type, rand_bytes(4));
    put_attr(sb.vlan_type, ascii_num(1234, 4));
    trim(2);
    send_frame();
    // Attribute length below two
    put_header(HDR_OK, 5);
    frame_q.push_back(FILLER_TYPE);
    frame_q.push_back(8'h01);
    put_attr(sb.name_type, rand_bytes(3));
    put_attr(sb.vlan_type, ascii_num(5, 1));
    send_frame();
    // Empty user name
    put_header(HDR_OK, 5);
    put_attr(sb.name_type, rand_bytes(0));
    put_attr(sb.vlan_type, ascii_num(5, 1));
    send_frame();
    // Bad VLAN values: zero, above 4094, no digit, empty
    for (int k = 0; k < 4; k++) begin
      put_header(HDR_OK, 5);
      put_attr(sb.name_type, rand_bytes(2));
      case (k)
        0: put_attr(sb.vlan_type, ascii_num(0, 1));
        1: put_attr(sb.vlan_type, ascii_num(4095, 4));
        2: put_attr(sb.vlan_type, '{8'h78});
        default: put_attr(sb.vlan_type, rand_bytes(0));
      endcase
      send_frame();
    end
    // Repeated attributes, later ones win; filler in between, empty or not
    put_header(HDR_OK, 5);
    put_attr(sb.name_type, rand_bytes(6));
    put_attr(FILLER_TYPE, rand_bytes(0));
    put_attr(sb.name_type, rand_bytes(2));
    put_attr(sb.vlan_type, ascii_num(9, 1));
    send_frame();
    put_header(HDR_OK, 5);
    put_attr(sb.vlan_type, ascii_num(3, 1));
    put_attr(FILLER_TYPE, rand_bytes(7));
    put_attr(sb.vlan_type, ascii_num(44, 2));
    put_attr(sb.name_type, rand_bytes(1));
    send_frame();
    // Attribute count limit: the last allowed slot, then one past it
    for (int extra = 62; extra <= 63; extra++) begin
      put_header(HDR_OK, 5);
      repeat (extra) put_attr(FILLER_TYPE, rand_bytes(0));
      put_attr(sb.name_type, rand_bytes(2));
      put_attr(sb.vlan_type, ascii_num(2, 1));
      send_frame();
    end
    // Extreme name bytes, junk after the scan has stopped
    put_header(HDR_OK, 5);
    put_attr(sb.name_type, '{8'hFF, 8'h01, 8'h80, 8'h7F});
    put_attr(sb.vlan_type, ascii_num(4094, 4));
    repeat (10) frame_q.push_back(8'($urandom));
    send_frame();
    // Name type equal to VLAN type: both attributes count as the name
    set_config(DEF_SRC_PORT, DEF_ACCEPT, DEF_VLAN_TYPE, DEF_VLAN_TYPE);
    put_header(HDR_OK, 5);
    put_attr(sb.name_type, rand_bytes(3));
    put_attr(sb.vlan_type, ascii_num(10, 2));
    send_frame();
  endtask

  initial begin
    logic [7:0] ntype;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    // Random frames under several register settings
    for (int phase_no = 0; phase_no < 6; phase_no++) begin
      ntype = 8'($urandom);
      case (phase_no)
        1: set_config(16'h0000, 8'h00, 8'h00, 8'hFF);
        2: set_config(16'hFFFF, 8'hFF, 8'hFF, 8'h00);
        3: set_config(16'($urandom), 8'($urandom), ntype,
                      ntype ^ 8'($urandom_range(1, 255)));
        4: set_config(16'($urandom), 8'($urandom), ntype, ntype);
        default: set_config(DEF_SRC_PORT, DEF_ACCEPT, DEF_NAME_TYPE, DEF_VLAN_TYPE);
      endcase
      repeat (8) begin
        build_random_frame();
        send_frame();
      end
    end
    wait_results();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
